// ===== hdl/atan2_decidegree_approx_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the atan2 approximation unit
// ---------------------------------------------------------------------------
`ifndef ATAN2_DECIDEGREE_APPROX_UNIT_ASSERT_SVH
`define ATAN2_DECIDEGREE_APPROX_UNIT_ASSERT_SVH

// property must hold whenever out of reset
`define ADA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the next cycle
`define ADA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/atan2_pkg.sv =====
// ---------------------------------------------------------------------------
// atan2_pkg
// Shared constants and widths for the atan2 approximation unit.
// ---------------------------------------------------------------------------
package atan2_pkg;
    localparam int INPUT_WIDTH_DEF = 32;
    localparam int ANGLE_W = 12;
    localparam int RATIO_W = 16;
    localparam int DEN_W = 17;
    localparam int NUM_W = 26;
    localparam int Q_W = 27;
    localparam logic [9:0] K_GAIN = 10'd573;
    localparam logic [14:0] K_QUAD = 15'd18350;
    localparam logic [11:0] K_HALF = 12'd900;
    localparam logic [11:0] K_FULL = 12'd1800;
endpackage

// ===== hdl/atan2_div.sv =====
// ---------------------------------------------------------------------------
// atan2_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module atan2_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 17,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quot,
    output logic [SIDE_W-1:0] side_out
);
    logic [NUM_W:0]    v_reg;
    logic [NUM_W-1:0]  n_reg [NUM_W+1];
    logic [DEN_W-1:0]  d_reg [NUM_W+1];
    logic [DEN_W-1:0]  r_reg [NUM_W+1];
    logic [SIDE_W-1:0] s_reg [NUM_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NUM_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= num;
            d_reg[0] <= den;
            r_reg[0] <= '0;
            s_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_st
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        assign trial = {r_reg[i], n_reg[i][NUM_W-1]};
        assign diff = trial - {1'b0, d_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1] <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
                n_reg[i+1] <= {n_reg[i][NUM_W-2:0], ~diff[DEN_W]};
                d_reg[i+1] <= d_reg[i];
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign quot = n_reg[NUM_W];
    assign side_out = s_reg[NUM_W];
endmodule

// ===== hdl/atan2_decidegree_approx_unit.sv =====
// ---------------------------------------------------------------------------
// atan2_decidegree_approx_unit
// Four-quadrant arctangent in tenths of a degree, fully pipelined.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_ready carries y_value and x_value; output channel
// out_valid/out_ready carries angle (-1800..1800, two's complement).
// One request is taken per cycle while the output register can move. The
// pipe runs through the magnitude and ordering stages, the ratio divider
// (W+17 quotient stages plus its input register), the r^2 and 0.28 r^2
// product stages, the Q10.16 divider (42 quotient stages plus its input
// register) and the quadrant fixup and output registers.
// One result is produced per cycle while the output is not stalled, as each
// divider has one stage per quotient bit.
// The whole pipe advances only when the output register is empty or taken,
// so a stalled receiver freezes all stages; nothing is lost or repeated.
// in_ready is high whenever the output register can move.
// Reset clears every valid bit, so the block is ready once reset is released.
// ---------------------------------------------------------------------------
module atan2_decidegree_approx_unit #(
    parameter int INPUT_WIDTH = atan2_pkg::INPUT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [31:0]                   y_value,
    input  logic signed [31:0]                   x_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [atan2_pkg::ANGLE_W-1:0] angle
);
    import atan2_pkg::*;
    `include "atan2_decidegree_approx_unit_assert.svh"

    localparam int W = INPUT_WIDTH;
    localparam int RN_W = W + RATIO_W;
    localparam int SIDE_W = 6;

    typedef struct packed {
        logic yneg;
        logic xneg;
        logic zero;
        logic swap;
        logic axz;
        logic spare;
    } side_t;

    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // stage 1: magnitudes
    logic          v1_reg;
    logic [W:0]    ay_reg, ax_reg;
    logic          yn_reg, xn_reg;
    logic [W-1:0]  ys, xs;
    assign ys = y_value[W-1:0];
    assign xs = x_value[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yn_reg <= ys[W-1];
            xn_reg <= xs[W-1];
            ay_reg <= ys[W-1] ? ({1'b0, ~ys} + 1'b1) : {1'b0, ys};
            ax_reg <= xs[W-1] ? ({1'b0, ~xs} + 1'b1) : {1'b0, xs};
        end
    end

    // stage 2: compare and order
    logic        v2_reg;
    logic [W:0]  lo_reg, hi_reg;
    side_t       s2_reg;
    logic        swp;
    assign swp = !(ay_reg < ax_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= swp ? ax_reg : ay_reg;
            hi_reg <= swp ? ay_reg : ax_reg;
            s2_reg.yneg <= yn_reg;
            s2_reg.xneg <= xn_reg;
            s2_reg.zero <= (ay_reg == '0) && (ax_reg == '0);
            s2_reg.swap <= swp;
            s2_reg.axz <= (ax_reg == '0);
            s2_reg.spare <= 1'b0;
        end
    end

    // ratio divider: (lo << 16) / hi, hi forced nonzero for the zero case
    logic              rv;
    logic [RN_W:0]     rq;
    logic [SIDE_W-1:0] rs;
    logic [W:0]        hi_safe;
    assign hi_safe = (hi_reg == '0) ? {{W{1'b0}}, 1'b1} : hi_reg;

    atan2_div #(.NUM_W(RN_W + 1), .DEN_W(W + 1), .SIDE_W(SIDE_W)) u_ratio (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2_reg),
        .num({lo_reg, {RATIO_W{1'b0}}}), .den(hi_safe), .side_in(s2_reg),
        .out_valid(rv), .quot(rq), .side_out(rs)
    );

    // stage: saturate, square
    logic          v3_reg;
    logic [15:0]   r3_reg;
    logic [31:0]   rsq_reg;
    side_t         s3_reg;
    logic [15:0]   rsat;
    assign rsat = (rq[RN_W:RATIO_W] != '0) ? 16'hFFFF : rq[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= rv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r3_reg <= rsat;
            rsq_reg <= rsat * rsat;
            s3_reg <= rs;
        end
    end

    // stage: 0.28 r^2 and numerator
    logic          v4_reg;
    logic [46:0]   qp_reg;
    logic [25:0]   num_reg;
    side_t         s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qp_reg <= K_QUAD * rsq_reg;
            num_reg <= K_GAIN * r3_reg;
            s4_reg <= s3_reg;
        end
    end

    logic [DEN_W-1:0] den;
    assign den = 17'h10000 + {2'b00, qp_reg[46:32]};

    logic              qv;
    logic [41:0]       qq;
    logic [SIDE_W-1:0] qs;

    atan2_div #(.NUM_W(42), .DEN_W(DEN_W), .SIDE_W(SIDE_W)) u_gain (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_reg),
        .num({num_reg, 16'h0000}), .den(den), .side_in(s4_reg),
        .out_valid(qv), .quot(qq), .side_out(qs)
    );

    // fixup stage 1: signed sum truncated to integer
    side_t       sq;
    logic        v5_reg;
    logic signed [12:0] a5_reg;
    side_t       s5_reg;
    logic [Q_W-1:0] qn;
    logic [27:0] base, vsum;
    assign sq = qs;
    assign qn = qq[Q_W-1:0];
    assign base = {6'd0, K_HALF, 10'd0} << 6;
    assign vsum = (sq.yneg != sq.xneg && !sq.axz) ? base + {1'b0, qn} : base - {1'b0, qn};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= qv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg <= sq;
            if (sq.swap)
                a5_reg <= $signed({1'b0, vsum[27:16]});
            else if (sq.yneg != sq.xneg)
                a5_reg <= -$signed({2'b00, qn[26:16]});
            else
                a5_reg <= $signed({2'b00, qn[26:16]});
        end
    end

    // fixup stage 2: quadrant offset, output register
    logic signed [12:0] fin;
    always_comb
    begin
        fin = a5_reg;
        if (s5_reg.zero)
            fin = '0;
        else if (s5_reg.swap)
        begin
            if (s5_reg.yneg)
                fin = a5_reg - $signed({1'b0, K_FULL});
        end
        else if (s5_reg.xneg)
        begin
            if (s5_reg.yneg)
                fin = a5_reg - $signed({1'b0, K_FULL});
            else
                fin = a5_reg + $signed({1'b0, K_FULL});
        end
    end

    logic                      ov_reg;
    logic signed [ANGLE_W-1:0] ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ang_reg <= fin[ANGLE_W-1:0];
    end

    assign out_valid = ov_reg;
    assign angle = ang_reg;

    `ADA_ASSERT(a_range, !out_valid || (angle >= -12'sd1800 && angle <= 12'sd1800),
        "angle out of range")
    `ADA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(angle),
        "output changed while stalled")
    `ADA_ASSERT(a_ready, in_ready == (!out_valid || out_ready), "ready mismatch")
endmodule

// ===== test/tb_atan2_decidegree_approx_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_atan2_decidegree_approx_unit
// Drives y/x requests through the atan2 unit under varied backpressure and
// checks every angle against a fixed-point prediction of the approximation.
// ---------------------------------------------------------------------------
module tb_atan2_decidegree_approx_unit;
    import atan2_pkg::*;

    localparam int IW = 32;
    localparam int LAT = IW + 40;
    localparam int WDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] y_value = '0;
    logic signed [31:0] x_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [ANGLE_W-1:0] angle;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    atan2_decidegree_approx_unit #(.INPUT_WIDTH(IW)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .y_value(y_value), .x_value(x_value), .out_valid(out_valid),
        .out_ready(out_ready), .angle(angle)
    );

    function automatic logic [ANGLE_W-1:0] angle_of(logic [31:0] y, logic [31:0] x);
        logic [32:0] ay, ax, lo, hi;
        logic yneg, xneg, diff;
        logic [63:0] r, rsq, den, num, q, v;
        int a;
        yneg = y[IW-1];
        xneg = x[IW-1];
        ay = yneg ? (33'h1_0000_0000 - {1'b0, y}) : {1'b0, y};
        ax = xneg ? (33'h1_0000_0000 - {1'b0, x}) : {1'b0, x};
        diff = yneg != xneg;
        if (ay == 0 && ax == 0)
            return '0;
        if (ay < ax)
        begin
            lo = ay;
            hi = ax;
        end
        else
        begin
            lo = ax;
            hi = ay;
        end
        r = (64'(lo) << 16) / 64'(hi);
        if (r > 65535)
            r = 65535;
        rsq = r * r;
        den = 64'd65536 + ((64'(K_QUAD) * rsq) >> 32);
        num = 64'(K_GAIN) * r;
        q = (num << 16) / den;
        if (ay < ax)
        begin
            a = diff ? -int'(q >> 16) : int'(q >> 16);
            if (xneg)
                a += yneg ? -1800 : 1800;
        end
        else
        begin
            v = (64'd900 << 16);
            v = (diff && ax != 0) ? v + q : v - q;
            a = int'(v >> 16);
            if (yneg)
                a -= 1800;
        end
        return a[ANGLE_W-1:0];
    endfunction

    class angle_scoreboard;
        logic [ANGLE_W-1:0] pending[$];
        int errors = 0;
        int checked = 0;

        function void note_request(logic [31:0] y, logic [31:0] x);
            pending.push_back(angle_of(y, x));
        endfunction

        function void check_angle(logic [ANGLE_W-1:0] got);
            logic [ANGLE_W-1:0] exp_angle;
            if (pending.size() == 0)
            begin
                $error("unexpected result angle=%0d", $signed(got));
                errors++;
                return;
            end
            exp_angle = pending.pop_front();
            checked++;
            if (exp_angle !== got)
            begin
                $error("angle mismatch: expected %0d actual %0d",
                       $signed(exp_angle), $signed(got));
                errors++;
            end
        endfunction
    endclass

    angle_scoreboard sb = new();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(y_value, x_value);
            if (out_valid && out_ready)
                sb.check_angle(angle);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (in_valid || sb.pending.size() != 0)
                idle_cycles <= idle_cycles + 1;
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog expired, %0d requests pending", sb.pending.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [31:0] y, logic [31:0] x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        y_value <= y;
        x_value <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000);
            2: return $urandom >> $urandom_range(31);
            3: return -($urandom >> $urandom_range(31));
            4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(4)) - 2);
        endcase
    endfunction

    task automatic run_random(int n, int sidle, int rstall);
        logic [31:0] y;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        repeat (n)
        begin
            y = rand_coord();
            case ($urandom_range(7))
                0: send_request(y, y);
                1: send_request(y, -y);
                default: send_request(y, rand_coord());
            endcase
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_request(0, 0);
        send_request(0, 5);
        send_request(0, -5);
        send_request(7, 0);
        send_request(-7, 0);
        send_request(32'h7fff_ffff, 32'h7fff_ffff);
        send_request(32'h8000_0000, 32'h8000_0000);
        send_request(32'h8000_0000, 32'h7fff_ffff);
        send_request(32'h7fff_ffff, 32'h8000_0000);
        send_request(32'h8000_0000, 0);
        send_request(0, 32'h8000_0000);
        send_request(1, 32'h7fff_ffff);
        send_request(-1, 32'h8000_0000);
        send_request(100, 100);
        send_request(100, -100);
        send_request(-100, 100);
        send_request(-100, -100);
        send_request(3, 4);
        send_request(-4, 3);
        send_request(32'hffff_ffff, 32'hffff_ffff);
        run_random(500, 0, 0);
        run_random(350, 88, 0);
        run_random(350, 0, 88);
        run_random(450, 35, 35);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LAT) @(posedge clk);
        $display("checked %0d angles over four backpressure phases incl. axis,",
                 sb.checked);
        $display("diagonal and full-scale corner requests");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/atan2_pkg.sv
hdl/atan2_div.sv
hdl/atan2_decidegree_approx_unit.sv
test/tb_atan2_decidegree_approx_unit.sv
